/* src/dlr_pkg.sv */
package dlr_pkg;

   // Item codes
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } command_type;

   // Classification that travels with each item through the queue
   typedef struct packed {
      command_type command;
      logic        steep;
      logic        minor_neg;
   } item_ctrl_type;

   // Register map
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam logic REG_DRAW_COLOR = 1'b0;

   localparam int COLOR_BITS = 24;
   localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFFFFFF;

   // Entries in the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

endpackage

/* src/dda_line_rasterizer_top.sv */
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// request  | start / busy          | req_command, req_start_x/y, req_end_x/y
// response | rsp_valid (1 cycle)   | rsp_pixel_x/y, rsp_pixel_color, rsp_last_pixel
// csr      | psel/penable/pready   | paddr, pwrite, pwdata, prdata (draw_color at 0x0)
//
// A step's pixel is registered at the outputs after the step leaves the queue; one pixel
// per cycle while no divide runs. A load holds the back end in the bit-serial slope
// divider, except when both endpoints share the major coordinate.
// busy rises when the two-entry queue between front and back is full.
// Reset is synchronous; no clearing pass follows it. Results cannot be stalled.
module dda_line_rasterizer_top #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  dlr_pkg::command_type                  req_command,
   input  logic signed [COORD_BITS-1:0]          req_start_x,
   input  logic signed [COORD_BITS-1:0]          req_start_y,
   input  logic signed [COORD_BITS-1:0]          req_end_x,
   input  logic signed [COORD_BITS-1:0]          req_end_y,
   output logic                                  rsp_valid,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [dlr_pkg::COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                                  rsp_last_pixel,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dlr_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [dlr_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [dlr_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import dlr_pkg::*;

   localparam int ITEM_W = $bits(item_ctrl_type) + 5 * COORD_BITS;

   logic                  queue_full;
   logic                  queue_empty;
   logic                  push;
   logic                  pop;
   item_ctrl_type         f_ctrl;
   logic [COORD_BITS-1:0] f_maj0, f_maj1, f_min0, f_dmaj, f_mag;
   item_ctrl_type         b_ctrl;
   logic [COORD_BITS-1:0] b_maj0, b_maj1, b_min0, b_dmaj, b_mag;
   logic [ITEM_W-1:0]     push_data;
   logic [ITEM_W-1:0]     pop_data;
   logic [COLOR_BITS-1:0] color_ff;
   logic [COLOR_BITS-1:0] color_in;
   logic                  csr_write;
   logic                  csr_index;

   // Register port: one colour register
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1];
   assign csr_write = psel && penable && pwrite && pready;
   assign color_in  = (csr_write && csr_index == REG_DRAW_COLOR) ?
                      pwdata[COLOR_BITS-1:0] : color_ff;
   assign prdata    = (csr_index == REG_DRAW_COLOR) ?
                      {{(CSR_DATA_W - COLOR_BITS){1'b0}}, color_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else begin
         color_ff <= color_in;
      end
   end

   // Classify items at the front
   dlr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .start       (start),
      .queue_full  (queue_full),
      .busy        (busy),
      .push        (push),
      .req_command (req_command),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .item_ctrl   (f_ctrl),
      .item_maj0   (f_maj0),
      .item_maj1   (f_maj1),
      .item_min0   (f_min0),
      .item_dmaj   (f_dmaj),
      .item_mag    (f_mag)
   );

   // Queue classified items for the back end
   assign push_data = {f_ctrl, f_maj0, f_maj1, f_min0, f_dmaj, f_mag};
   assign {b_ctrl, b_maj0, b_maj1, b_min0, b_dmaj, b_mag} = pop_data;

   dlr_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // Divide on loads, walk the line on steps
   dlr_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (!queue_empty),
      .q_pop           (pop),
      .q_ctrl          (b_ctrl),
      .q_maj0          (b_maj0),
      .q_maj1          (b_maj1),
      .q_min0          (b_min0),
      .q_dmaj          (b_dmaj),
      .q_mag           (b_mag),
      .draw_color      (color_ff),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

/* src/dlr_front.sv */
module dlr_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                          start,
   input  logic                          queue_full,
   output logic                          busy,
   output logic                          push,
   input  dlr_pkg::command_type          req_command,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   output dlr_pkg::item_ctrl_type        item_ctrl,
   output logic [COORD_BITS-1:0]         item_maj0,
   output logic [COORD_BITS-1:0]         item_maj1,
   output logic [COORD_BITS-1:0]         item_min0,
   output logic [COORD_BITS-1:0]         item_dmaj,
   output logic [COORD_BITS-1:0]         item_mag
);
   import dlr_pkg::*;

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic signed [COORD_BITS:0] dx_neg;
   logic signed [COORD_BITS:0] dy_neg;
   logic [COORD_BITS-1:0]      adx;
   logic [COORD_BITS-1:0]      ady;
   logic                       steep;
   logic                       swap;
   logic signed [COORD_BITS:0] d_minor;
   logic                       d_minor_pos;
   logic                       d_minor_neg;

   // Accept while the queue has room
   assign busy = queue_full;
   assign push = start && !queue_full;

   // Take the deltas and their magnitudes
   assign dx     = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
   assign dy     = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
   assign ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

   // Pick the major axis and order the endpoints so that it rises
   assign steep = ady > adx;
   assign swap  = steep ? (req_start_y > req_end_y) : (req_start_x > req_end_x);

   assign d_minor     = steep ? dx : dy;
   assign d_minor_neg = d_minor[COORD_BITS];
   assign d_minor_pos = !d_minor[COORD_BITS] && (d_minor != '0);

   always_comb begin
      item_ctrl.command   = req_command;
      item_ctrl.steep     = steep;
      item_ctrl.minor_neg = swap ? d_minor_pos : d_minor_neg;
      item_dmaj = steep ? ady : adx;
      item_mag  = steep ? adx : ady;
      if (steep) begin
         item_maj0 = swap ? req_end_y : req_start_y;
         item_maj1 = swap ? req_start_y : req_end_y;
         item_min0 = swap ? req_end_x : req_start_x;
      end else begin
         item_maj0 = swap ? req_end_x : req_start_x;
         item_maj1 = swap ? req_start_x : req_end_x;
         item_min0 = swap ? req_end_y : req_start_y;
      end
   end

endmodule

/* src/dlr_queue.sv */
module dlr_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   import dlr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data = entries_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue pushed while full");
`endif

endmodule

/* src/dlr_back.sv */
module dlr_back #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  dlr_pkg::item_ctrl_type          q_ctrl,
   input  logic [COORD_BITS-1:0]           q_maj0,
   input  logic [COORD_BITS-1:0]           q_maj1,
   input  logic [COORD_BITS-1:0]           q_min0,
   input  logic [COORD_BITS-1:0]           q_dmaj,
   input  logic [COORD_BITS-1:0]           q_mag,
   input  logic [dlr_pkg::COLOR_BITS-1:0]  draw_color,
   output logic                            rsp_valid,
   output logic signed [COORD_BITS-1:0]    rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]    rsp_pixel_y,
   output logic [dlr_pkg::COLOR_BITS-1:0]  rsp_pixel_color,
   output logic                            rsp_last_pixel
);
   import dlr_pkg::*;

   localparam int NUM_W   = COORD_BITS + FRAC_BITS + 2;
   localparam int DEN_W   = COORD_BITS + 1;
   localparam int ACC_W   = COORD_BITS + FRAC_BITS + 1;
   localparam int SLOPE_W = FRAC_BITS + 2;
   localparam int CNT_W   = $clog2(NUM_W + 1);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } back_state_type;

   back_state_type              state_ff, state_in;
   logic                        line_active_ff, line_active_in;
   logic                        steep_ff, steep_in;
   logic                        minor_neg_ff, minor_neg_in;
   logic signed [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [SLOPE_W-1:0]   slope_ff, slope_in;
   logic [NUM_W-1:0]            div_num_ff, div_num_in;
   logic [DEN_W-1:0]            div_rem_ff, div_rem_in;
   logic [DEN_W-1:0]            div_den_ff, div_den_in;
   logic [CNT_W-1:0]            div_cnt_ff, div_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic [COLOR_BITS-1:0]       rsp_color_ff, rsp_color_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [DEN_W:0]              trial;
   logic [DEN_W:0]              trial_diff;
   logic                        trial_ge;
   logic [NUM_W-1:0]            num_shift;
   logic signed [SLOPE_W-1:0]   quot_ext;
   logic signed [ACC_W-1:0]     round_sum;
   logic signed [COORD_BITS-1:0] minor_pixel;
   logic                        last;

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   // One restoring divide step: shift in a numerator bit, subtract if it fits
   assign trial      = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, div_den_ff};
   assign trial_ge   = trial >= {1'b0, div_den_ff};
   assign num_shift  = {div_num_ff[NUM_W-2:0], trial_ge};
   assign quot_ext   = {1'b0, num_shift[FRAC_BITS:0]};

   // Round the accumulator half away from zero in one add
   assign round_sum   = acc_ff + ROUND_HALF - ACC_W'(acc_ff[ACC_W-1]);
   assign minor_pixel = round_sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
   assign last        = major_pos_ff >= major_end_ff;

   always_comb begin
      state_in       = state_ff;
      line_active_in = line_active_ff;
      steep_in       = steep_ff;
      minor_neg_in   = minor_neg_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      acc_in         = acc_ff;
      slope_in       = slope_ff;
      div_num_in     = div_num_ff;
      div_rem_in     = div_rem_ff;
      div_den_in     = div_den_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop && q_ctrl.command == CMD_LOAD) begin
               // Latch the new line and start the slope divide unless the major delta is zero
               line_active_in = 1'b1;
               steep_in       = q_ctrl.steep;
               minor_neg_in   = q_ctrl.minor_neg;
               major_pos_in   = q_maj0;
               major_end_in   = q_maj1;
               acc_in         = {q_min0[COORD_BITS-1], q_min0, {FRAC_BITS{1'b0}}};
               slope_in       = '0;
               div_num_in     = NUM_W'({q_mag, {(FRAC_BITS + 1){1'b0}}}) + NUM_W'(q_dmaj);
               div_den_in     = {q_dmaj, 1'b0};
               div_rem_in     = '0;
               div_cnt_in     = CNT_W'(NUM_W);
               if (q_dmaj != '0) begin
                  state_in = ST_DIVIDE;
               end
            end else if (q_pop && q_ctrl.command == CMD_STEP && line_active_ff) begin
               // Emit one pixel, then advance along the major axis or end the line on its last pixel
               rsp_valid_in = 1'b1;
               rsp_x_in     = steep_ff ? minor_pixel : major_pos_ff;
               rsp_y_in     = steep_ff ? major_pos_ff : minor_pixel;
               rsp_color_in = draw_color;
               rsp_last_in  = last;
               if (last) begin
                  line_active_in = 1'b0;
               end else begin
                  major_pos_in = major_pos_ff + 1'b1;
                  acc_in       = acc_ff + ACC_W'(slope_ff);
               end
            end
         end
         ST_DIVIDE: begin
            div_num_in = num_shift;
            div_rem_in = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            div_cnt_in = CNT_W'(div_cnt_ff - 1'b1);
            if (div_cnt_ff == CNT_W'(1)) begin
               slope_in = minor_neg_ff ? -quot_ext : quot_ext;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_active_ff <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold line and result payload
   always_ff @(posedge clock) begin
      steep_ff     <= steep_in;
      minor_neg_ff <= minor_neg_in;
      major_pos_ff <= major_pos_in;
      major_end_ff <= major_end_in;
      acc_ff       <= acc_in;
      slope_ff     <= slope_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

`ifndef SYNTHESIS
   a_pixel_needs_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(line_active_ff))
      else $error("pixel emitted with no active line");
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> !line_active_ff)
      else $error("line still active after its last pixel");
   a_divide_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (line_active_ff && !q_pop))
      else $error("divide running without a line or while popping");
`endif

endmodule

/* test/dda_line_rasterizer_top_test.sv */
`timescale 1ns / 100ps

module dda_line_rasterizer_top_test;
   import dlr_pkg::*;

   localparam int COORD_BITS    = 12;
   localparam int FRAC_BITS     = 16;
   // one bit of headroom: rounding drift can carry the minor just past the coordinate range
   localparam int ACC_BITS      = COORD_BITS + FRAC_BITS + 1;
   localparam int SLOPE_BITS    = FRAC_BITS + 2;
   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
   // slope divide plus queue and output stages, with margin
   localparam int SETTLE_CYCLES = 64;
   localparam int RESET_CYCLES  = 11;
   localparam int RUN_LIMIT_NS  = 10_000_000;
   localparam int MAX_WALK      = 150;

   localparam logic [CSR_ADDR_W-1:0] COLOUR_ADDR   = {REG_DRAW_COLOR, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_DRAW_COLOR, 2'b00};

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type             x;
      coord_type             y;
      logic [COLOR_BITS-1:0] colour;
      logic                  last;
   } pixel_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   command_type            req_command;
   coord_type              req_start_x;
   coord_type              req_start_y;
   coord_type              req_end_x;
   coord_type              req_end_y;
   logic                   rsp_valid;
   coord_type              rsp_pixel_x;
   coord_type              rsp_pixel_y;
   logic [COLOR_BITS-1:0]  rsp_pixel_color;
   logic                   rsp_last_pixel;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   // Line walker state mirrored from the block
   logic [COLOR_BITS-1:0]  model_colour;
   logic                   line_live;
   logic                   line_steep;
   coord_type              walk_pos;
   coord_type              walk_end;
   logic signed [ACC_BITS-1:0]   minor_acc;
   logic signed [SLOPE_BITS-1:0] minor_slope;

   pixel_type   pending_pixels[$];
   int unsigned sender_idle_pct;
   int unsigned items_counted;
   int unsigned loads_sent;
   int unsigned pixels_seen;
   int unsigned lines_done;
   int unsigned failures;

   dda_line_rasterizer_top #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Update the line walker for one accepted item; queue the pixel it emits
   task automatic rasterise(input command_type cmd, input coord_type sx, input coord_type sy,
                            input coord_type ex, input coord_type ey, output bit emitted);
      longint ax, ay, bx, by, dx, dy, adx, ady;
      longint maj0, maj1, min0, dmin, dmaj, mag, q, acc, minor, half;
      pixel_type px;
      emitted = 1'b0;
      half = longint'(1) << (FRAC_BITS - 1);
      if (cmd == CMD_LOAD) begin
         ax = sx;
         ay = sy;
         bx = ex;
         by = ey;
         dx = bx - ax;
         dy = by - ay;
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         line_steep = ady > adx;
         // order the endpoints so that the major coordinate rises
         if (!line_steep) begin
            if (ax <= bx) begin
               maj0 = ax; maj1 = bx; min0 = ay; dmin = dy;
            end else begin
               maj0 = bx; maj1 = ax; min0 = by; dmin = -dy;
            end
         end else begin
            if (ay <= by) begin
               maj0 = ay; maj1 = by; min0 = ax; dmin = dx;
            end else begin
               maj0 = by; maj1 = ay; min0 = bx; dmin = -dx;
            end
         end
         dmaj = maj1 - maj0;
         // slope rounded to nearest, halves away from zero
         if (dmaj == 0) begin
            q = 0;
         end else begin
            mag = dmin < 0 ? -dmin : dmin;
            q = ((mag << (FRAC_BITS + 1)) + dmaj) / (2 * dmaj);
            if (dmin < 0) q = -q;
         end
         minor_slope = SLOPE_BITS'(q);
         walk_pos    = coord_type'(maj0);
         walk_end    = coord_type'(maj1);
         minor_acc   = ACC_BITS'(min0 * (longint'(1) << FRAC_BITS));
         line_live   = 1'b1;
      end else if (line_live) begin
         acc = minor_acc;
         if (acc >= 0) minor = (acc + half) >>> FRAC_BITS;
         else minor = -((-acc + half) >>> FRAC_BITS);
         px.last = walk_pos >= walk_end;
         if (line_steep) begin
            px.x = coord_type'(minor);
            px.y = walk_pos;
         end else begin
            px.x = walk_pos;
            px.y = coord_type'(minor);
         end
         px.colour = model_colour;
         pending_pixels.push_back(px);
         emitted = 1'b1;
         if (px.last) begin
            line_live = 1'b0;
         end else begin
            walk_pos  += 1;
            minor_acc += minor_slope;
         end
      end
   endtask

   // Offer one item, idling first as the phase asks, and hold until taken
   task automatic send_command(input command_type cmd, input coord_type sx, input coord_type sy,
                               input coord_type ex, input coord_type ey);
      bit emitted;
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (busy);
      rasterise(cmd, sx, sy, ex, ey, emitted);
      if (cmd == CMD_LOAD) loads_sent++;
      if (cmd == CMD_LOAD || emitted) items_counted++;
   endtask

   // Load a line, then issue steps carrying random don't-care coordinates
   task automatic trace_line(input coord_type sx, input coord_type sy, input coord_type ex,
                             input coord_type ey, input int unsigned steps);
      send_command(CMD_LOAD, sx, sy, ex, ey);
      repeat (steps)
         send_command(CMD_STEP, coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom));
   endtask

   // Drop start and hold until every pixel owed has arrived
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // Let any load still in the divider finish as well
   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Bus transfers leave psel high; the caller releases the bus afterwards
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == COLOUR_ADDR) model_colour = data[COLOR_BITS-1:0];
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
   endtask

   task automatic test_colour_reset();
      logic [CSR_DATA_W-1:0] readback;
      csr_read(COLOUR_ADDR, readback);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[COLOR_BITS-1:0] !== COLOR_RESET) begin
         $error("draw_color after reset: expected %06h, got %06h",
                COLOR_RESET, readback[COLOR_BITS-1:0]);
         failures++;
      end
   endtask

   // Set the colour with junk in the spare bits, poke the unmapped slot, read back
   task automatic test_colour_setting(input logic [COLOR_BITS-1:0] colour);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-COLOR_BITS-1:0] junk;
      settle();
      junk = $urandom;
      csr_write(COLOUR_ADDR, {junk, colour});
      csr_write(UNMAPPED_ADDR, $urandom);
      csr_read(COLOUR_ADDR, readback);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[COLOR_BITS-1:0] !== model_colour) begin
         $error("draw_color readback: expected %06h, got %06h",
                model_colour, readback[COLOR_BITS-1:0]);
         failures++;
      end
   endtask

   task automatic test_directed_lines();
      sender_idle_pct = 0;
      // step before any line is loaded: silence
      send_command(CMD_STEP, 0, 0, 0, 0);
      // single point, then a step past its only pixel
      trace_line(5, -7, 5, -7, 2);
      // full-range diagonal, then replaced by the reversed anti-diagonal
      trace_line(-2048, -2048, 2047, 2047, 2);
      trace_line(2047, -2048, -2048, 2047, 2);
      // steep line given top-down, walked to the end and one beyond
      trace_line(1, 3, 0, 0, 5);
      // half-pixel minors on either side of zero
      trace_line(0, 0, 2, -1, 3);
      trace_line(2, 1, 0, 0, 3);
   endtask

   function automatic coord_type near_coord(input coord_type base, input int unsigned span);
      longint v;
      v = longint'(base) + longint'($urandom_range(2 * span)) - longint'(span);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return coord_type'(v);
   endfunction

   // Mostly whole short lines, some abandoned or overrun, a little noise
   task automatic test_random_lines(input int unsigned quota);
      int unsigned goal;
      int unsigned round_no;
      int unsigned pick, kind, span, steps, walk_len;
      coord_type sx, sy, ex, ey;
      longint adx, ady;
      goal = items_counted + quota;
      round_no = 0;
      while (items_counted < goal) begin
         round_no++;
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_command(command_type'($urandom_range(1)), coord_type'($urandom),
                         coord_type'($urandom), coord_type'($urandom),
                         coord_type'($urandom));
         end else begin
            if (pick < 11 || round_no == 20) hold_until_drained();
            sx = coord_type'($urandom);
            sy = coord_type'($urandom);
            kind = $urandom_range(99);
            if (kind >= 97) begin
               ex = coord_type'($urandom);
               ey = coord_type'($urandom);
            end else begin
               span = kind < 4 ? 0 : kind < 70 ? 8 : kind < 90 ? 64 : 400;
               ex = near_coord(sx, span);
               ey = near_coord(sy, span);
            end
            adx = longint'(ex) - longint'(sx);
            ady = longint'(ey) - longint'(sy);
            if (adx < 0) adx = -adx;
            if (ady < 0) ady = -ady;
            walk_len = int'(adx > ady ? adx : ady) + 1;
            pick = $urandom_range(99);
            if (pick < 75) steps = walk_len;
            else if (pick < 90) steps = walk_len + $urandom_range(3, 1);
            else steps = $urandom_range(walk_len);
            if (steps > MAX_WALK) steps = MAX_WALK;
            trace_line(sx, sy, ex, ey, steps);
         end
      end
   endtask

   // Compare each pixel with the oldest one owed
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel with none owed: x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y);
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_seen++;
            if (want.last) lines_done++;
            if (rsp_pixel_x !== want.x) begin
               $error("pixel_x: expected %0d, got %0d", want.x, rsp_pixel_x);
               failures++;
            end
            if (rsp_pixel_y !== want.y) begin
               $error("pixel_y: expected %0d, got %0d", want.y, rsp_pixel_y);
               failures++;
            end
            if (rsp_pixel_color !== want.colour) begin
               $error("pixel_color: expected %06h, got %06h", want.colour, rsp_pixel_color);
               failures++;
            end
            if (rsp_last_pixel !== want.last) begin
               $error("last_pixel: expected %0b, got %0b", want.last, rsp_last_pixel);
               failures++;
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("dda_line_rasterizer_top regression: fail");
      $finish;
   end

   initial begin
      start       <= 1'b0;
      req_command <= CMD_LOAD;
      req_start_x <= '0;
      req_start_y <= '0;
      req_end_x   <= '0;
      req_end_y   <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      reset       <= 1'b1;
      model_colour = COLOR_RESET;
      line_live    = 1'b0;
      line_steep   = 1'b0;
      walk_pos     = '0;
      walk_end     = '0;
      minor_acc    = '0;
      minor_slope  = '0;
      sender_idle_pct = 0;
      items_counted = 0;
      loads_sent    = 0;
      pixels_seen   = 0;
      lines_done    = 0;
      failures      = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_colour_reset();
      test_directed_lines();
      test_colour_setting('0);
      sender_idle_pct = 0;
      test_random_lines(650);
      test_colour_setting(COLOR_BITS'($urandom));
      sender_idle_pct = 80;
      test_random_lines(650);
      test_colour_setting(COLOR_RESET);
      sender_idle_pct = 12;
      test_random_lines(650);

      // wind down
      settle();
      $display("covered %0d items (%0d line loads) over three colour settings and three",
               items_counted, loads_sent);
      $display("sender idle rates; %0d pixels checked, %0d lines walked to their end",
               pixels_seen, lines_done);
      if (failures == 0 && pending_pixels.size() == 0)
         $display("dda_line_rasterizer_top regression: pass");
      else
         $display("dda_line_rasterizer_top regression: fail");
      $finish;
   end

endmodule
